>>> rtl/dbs_pkg.sv
// Shared types and constants for the DMA burst splitter.
// Used by dbs_ctrl, dbs_datapath and dma_burst_splitter; no dependencies.
`timescale 1ns / 1ps

package dbs_pkg;

  localparam int PAGE_BYTES        = 4096;
  localparam int MAX_REQUEST_BYTES = 12288;
  localparam int MIN_BURST_BYTES   = 256;

  localparam int ADDR_W    = 64;
  localparam int PAGE_W    = $clog2(PAGE_BYTES);
  localparam int BYTES_W   = PAGE_W + 1;
  localparam int COUNT_W   = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int BEAT_W    = 8;
  localparam int BEAT_SH_W = $clog2(BEAT_W);
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = BYTES_W;

  localparam logic [BEAT_W-1:0]  BEAT_BYTES_RESET = BEAT_W'(16);
  localparam logic [BYTES_W-1:0] MAX_BURST_RESET  = BYTES_W'(PAGE_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BURST  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SPLIT,
    ST_ERROR
  } dbs_state_e;

  typedef struct packed {
    logic load_req;
    logic emit_burst;
    logic emit_err;
  } dbs_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic out_free;
    logic burst_last;
  } dbs_status_t;

endpackage

>>> rtl/dbs_ctrl.sv
// Controller state machine of the DMA burst splitter.
// Depends on dbs_pkg; drives commands into dbs_datapath.
`timescale 1ns / 1ps

module dbs_ctrl import dbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dbs_status_t status_i,
  output dbs_cmd_t    cmd_o
);

  dbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = status_i.req_bad ? ST_ERROR : ST_SPLIT;
      end
      ST_SPLIT: begin
        if (status_i.out_free && status_i.burst_last) state_d = ST_IDLE;
      end
      ST_ERROR: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    cmd_o.load_req   = 1'b0;
    cmd_o.emit_burst = 1'b0;
    cmd_o.emit_err   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_EVAL: ;
      ST_SPLIT: cmd_o.emit_burst = status_i.out_free;
      ST_ERROR: cmd_o.emit_err   = status_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/dbs_datapath.sv
// Datapath of the DMA burst splitter: configuration, request state,
// burst arithmetic and the output register. Depends on dbs_pkg.
`timescale 1ns / 1ps

module dbs_datapath import dbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ADDR_W-1:0]     start_address_i,
  input  logic [COUNT_W-1:0]    byte_count_i,
  input  dbs_cmd_t              cmd_i,
  output dbs_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     burst_address_o,
  output logic [BYTES_W-1:0]    burst_bytes_o,
  output logic [BYTES_W-1:0]    burst_beats_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic                  last_o
);

  logic [BEAT_W-1:0]   beat_q;
  logic [BYTES_W-1:0]  maxb_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [COUNT_W-1:0]  left_q;

  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [BYTES_W-1:0]  out_bytes_q;
  logic [BYTES_W-1:0]  out_beats_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic [BEAT_W-1:0]    beat_mask;
  logic                 geom_bad;
  logic [ADDR_W:0]      end_sum;
  logic                 overflow;
  logic [BYTES_W-1:0]   page_room;
  logic [BYTES_W-1:0]   cand;
  logic [BYTES_W-1:0]   burst_len;
  logic [BEAT_SH_W-1:0] beat_sh;
  logic [COUNT_W-1:0]   round_up;
  logic [BYTES_W-1:0]   beats;
  logic                 out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= BEAT_BYTES_RESET;
      maxb_q <= MAX_BURST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BEAT_BYTES: beat_q <= cfg_data_i[BEAT_W-1:0];
        CFG_MAX_BURST:  maxb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Validity checks; a divisor of the page size is a power of two.
  always_comb begin
    beat_mask = beat_q - BEAT_W'(1);
    geom_bad  = (left_q == '0)
             || (left_q > COUNT_W'(MAX_REQUEST_BYTES))
             || (beat_q == '0)
             || ((beat_q & beat_mask) != '0)
             || ((addr_q[BEAT_W-1:0] & beat_mask) != '0)
             || (maxb_q < BYTES_W'(MIN_BURST_BYTES))
             || (maxb_q > BYTES_W'(PAGE_BYTES))
             || ((maxb_q[BEAT_W-1:0] & beat_mask) != '0);
    end_sum   = {1'b0, addr_q} + (ADDR_W + 1)'(left_q);
    overflow  = end_sum[ADDR_W];
  end

  // Burst length is the least of what remains, the maximum burst and the
  // room left in the current page.
  always_comb begin
    page_room = BYTES_W'(PAGE_BYTES) - BYTES_W'(addr_q[PAGE_W-1:0]);
    cand      = (left_q > COUNT_W'(maxb_q)) ? maxb_q : left_q[BYTES_W-1:0];
    burst_len = (page_room < cand) ? page_room : cand;
    beat_sh   = '0;
    for (int i = 0; i < BEAT_W; i++) begin
      if (beat_q[i]) beat_sh = BEAT_SH_W'(i);
    end
    round_up  = COUNT_W'(burst_len) + COUNT_W'(beat_q) - COUNT_W'(1);
    beats     = BYTES_W'(round_up >> beat_sh);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      addr_q <= start_address_i;
      left_q <= byte_count_i;
    end else if (cmd_i.emit_burst) begin
      addr_q <= addr_q + ADDR_W'(burst_len);
      left_q <= left_q - COUNT_W'(burst_len);
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = (cmd_i.emit_burst || cmd_i.emit_err) ? 1'b1
                     : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_addr_q   <= addr_q;
      out_bytes_q  <= '0;
      out_beats_q  <= '0;
      out_status_q <= geom_bad ? STATUS_INVALID : STATUS_OVERFLOW;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_burst) begin
      out_addr_q   <= addr_q;
      out_bytes_q  <= burst_len;
      out_beats_q  <= beats;
      out_status_q <= STATUS_OK;
      out_last_q   <= (left_q == COUNT_W'(burst_len));
    end
  end

  assign status_o.req_bad    = geom_bad || overflow;
  assign status_o.out_free   = out_free;
  assign status_o.burst_last = (left_q == COUNT_W'(burst_len));

  assign out_valid_o     = out_valid_q;
  assign burst_address_o = out_addr_q;
  assign burst_bytes_o   = out_bytes_q;
  assign burst_beats_o   = out_beats_q;
  assign out_status_o    = out_status_q;
  assign last_o          = out_last_q;

endmodule

>>> rtl/dma_burst_splitter.sv
// DMA burst splitter, top level. Depends on dbs_pkg, dbs_ctrl and
// dbs_datapath.
// A request of start address and byte count is taken while idle, checked
// in the evaluation state, and then issues one burst word per cycle while
// the output is not stalled; the burst arithmetic in the datapath is
// combinational. Each burst stops at the page boundary, the configured
// maximum burst or the end of the request. An invalid request, or one
// running past the top of the address space, gives a single error word
// with last set. Configuration writes are always taken and must be made
// while idle.
`timescale 1ns / 1ps

module dma_burst_splitter import dbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_W-1:0]     start_address_i,
  input  logic [COUNT_W-1:0]    byte_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     burst_address_o,
  output logic [BYTES_W-1:0]    burst_bytes_o,
  output logic [BYTES_W-1:0]    burst_beats_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  last_o
);

  dbs_cmd_t    cmd;
  dbs_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  dbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  dbs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_address_i (start_address_i),
    .byte_count_i    (byte_count_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .burst_address_o (burst_address_o),
    .burst_bytes_o   (burst_bytes_o),
    .burst_beats_o   (burst_beats_o),
    .out_status_o    (status_o),
    .last_o          (last_o)
  );

endmodule
